/* rtl/core/abkf_pkg.sv */
package abkf_pkg;

   localparam int WordBits = 32;
   localparam int FracBits = 16;
   localparam int AddrBits = 5;

   typedef logic signed [WordBits-1:0] word_type;

   // register byte addresses
   typedef enum logic [AddrBits-1:0] {
      REG_INITIAL_VALUE = 5'd0,
      REG_LIFESPAN      = 5'd4,
      REG_NOISE_VALUE   = 5'd8,
      REG_NOISE_BIAS    = 5'd12,
      REG_MEAS_NOISE    = 5'd16
   } reg_addr_type;

   localparam logic signed [WordBits-1:0] MaxPos = {1'b0, {(WordBits-1){1'b1}}};
   localparam logic signed [WordBits-1:0] MinNeg = {1'b1, {(WordBits-1){1'b0}}};

   // saturating add and subtract
   function automatic word_type add_sat(word_type a, word_type b);
      logic signed [WordBits:0] s;
      begin
         s = {a[WordBits-1], a} + {b[WordBits-1], b};
         if (s[WordBits] != s[WordBits-1]) begin
            add_sat = s[WordBits] ? MinNeg : MaxPos;
         end else begin
            add_sat = s[WordBits-1:0];
         end
      end
   endfunction

   function automatic word_type sub_sat(word_type a, word_type b);
      logic signed [WordBits:0] s;
      begin
         s = {a[WordBits-1], a} - {b[WordBits-1], b};
         if (s[WordBits] != s[WordBits-1]) begin
            sub_sat = s[WordBits] ? MinNeg : MaxPos;
         end else begin
            sub_sat = s[WordBits-1:0];
         end
      end
   endfunction

   // magnitude of a signed word as an unsigned word
   function automatic logic [WordBits-1:0] mag_of(word_type a);
      begin
         mag_of = a[WordBits-1] ? (~a + 1'b1) : a;
      end
   endfunction

   // saturate sign and magnitude to the word range
   function automatic word_type from_mag(logic neg, logic [2*WordBits-1:0] m);
      logic [2*WordBits-1:0] lim;
      logic [2*WordBits-1:0] mm;
      begin
         lim = neg ? {{WordBits{1'b0}}, 1'b1, {(WordBits-1){1'b0}}}
                   : {{(WordBits+1){1'b0}}, {(WordBits-1){1'b1}}};
         mm = (m > lim) ? lim : m;
         from_mag = neg ? word_type'(~mm[WordBits-1:0] + 1'b1) : word_type'(mm[WordBits-1:0]);
      end
   endfunction

   // sequencer op codes for the shared unit
   typedef enum logic [2:0] {
      OP_MUL = 3'd0,
      OP_DIV = 3'd1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      word_type a;
      word_type b;
   } unit_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } unit_rsp_type;

endpackage

/* rtl/core/abkf_unit.sv */
// shared multiply and divide unit: 32x32 product registered in the cycle after the
// start, restoring division one quotient bit per cycle
module abkf_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  abkf_pkg::unit_req_type req,
   output abkf_pkg::unit_rsp_type rsp
);
   import abkf_pkg::*;

   localparam int NumBits = WordBits + FracBits;
   localparam int CntBits = $clog2(NumBits + 1);

   logic                      busy_ff, busy_in;
   logic                      neg_ff, neg_in;
   logic [NumBits-1:0]        num_ff, num_in;
   logic [WordBits:0]         rem_ff, rem_in;
   logic [NumBits-1:0]        quo_ff, quo_in;
   logic [WordBits-1:0]       den_ff, den_in;
   logic [CntBits-1:0]        cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   word_type                  res_ff, res_in;
   logic [2*WordBits-1:0]     prod;
   logic [WordBits:0]         trial;

   assign prod  = mag_of(req.a) * mag_of(req.b);
   assign trial = {rem_ff[WordBits-1:0], num_ff[NumBits-1]};

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (busy_ff) begin
         num_in = {num_ff[NumBits-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = from_mag(neg_ff, {{(2*WordBits-NumBits){1'b0}}, quo_in});
         end
      end else if (req.start) begin
         if (req.op == OP_MUL) begin
            done_in = 1'b1;
            res_in  = from_mag(req.a[WordBits-1] ^ req.b[WordBits-1],
                               prod >> FracBits);
         end else if (req.b == '0) begin
            done_in = 1'b1;
            res_in  = '0;
         end else begin
            busy_in = 1'b1;
            neg_in  = req.a[WordBits-1] ^ req.b[WordBits-1];
            num_in  = {mag_of(req.a), {FracBits{1'b0}}};
            den_in  = mag_of(req.b);
            rem_in  = '0;
            quo_in  = '0;
            cnt_in  = CntBits'(NumBits);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
endmodule

/* rtl/core/angle_bias_kalman_filter_core.sv */
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_restart, req_measured_value,
//         |           | req_measured_rate, req_elapsed_time
// rsp     | out       | rsp_valid, rsp_stall, rsp_estimate, rsp_rate_estimate,
//         |           | rsp_bias_estimate, rsp_previous_estimate, rsp_expired
// csr     | in        | csr_psel .. csr_prdata (APB-style)
// a filter step runs through acceptance, ten multiplies and two divides (48
// quotient bits each), the settle state ST_PREP and the result state ST_OUT,
// all through one shared unit
// restart and expired words go from acceptance straight to the result state
// reset clears state and loads register defaults, synchronous active high
// req_stall stays high from acceptance until the result word is taken
module angle_bias_kalman_filter_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   input  logic signed [31:0]       req_measured_value,
   input  logic signed [31:0]       req_measured_rate,
   input  logic [31:0]              req_elapsed_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_estimate,
   output logic signed [31:0]       rsp_rate_estimate,
   output logic signed [31:0]       rsp_bias_estimate,
   output logic signed [31:0]       rsp_previous_estimate,
   output logic                     rsp_expired,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [abkf_pkg::AddrBits-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import abkf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_WAIT = 5'b00100,
      ST_OUT = 5'b01000,
      ST_PREP = 5'b10000
   } state_type;

   // step indices of the sequence
   localparam logic [3:0] S_RATE_DT = 4'd0;  // dt*rate
   localparam logic [3:0] S_T       = 4'd1;  // dt*p11
   localparam logic [3:0] S_P00     = 4'd2;  // dt*(...)
   localparam logic [3:0] S_P11     = 4'd3;  // qb*dt
   localparam logic [3:0] S_K0      = 4'd4;
   localparam logic [3:0] S_K1      = 4'd5;
   localparam logic [3:0] S_V       = 4'd6;  // k0*y
   localparam logic [3:0] S_B       = 4'd7;  // k1*y
   localparam logic [3:0] S_C0      = 4'd8;  // k0*p00
   localparam logic [3:0] S_C1      = 4'd9;  // k1*p01
   localparam logic [3:0] S_C2      = 4'd10; // k1*p00
   localparam logic [3:0] S_C3      = 4'd11; // k0*p01

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   word_type    init_ff, nv_ff, nb_ff, mn_ff;
   logic [31:0] life_ff;
   word_type    val_ff, val_in, bias_ff, bias_in, rate_ff, rate_in, prior_ff, prior_in;
   word_type    p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   word_type    t_ff, t_in, k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   word_type    mv_ff, mv_in, dt_ff, dt_in;
   logic        exp_ff, exp_in;
   logic        wr;
   unit_req_type ureq;
   unit_rsp_type ursp;
   word_type    r;

   abkf_unit u_unit (.clock(clock), .reset(reset), .req(ureq), .rsp(ursp));

   // configuration port
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         life_ff <= 32'd65536;
         nv_ff   <= 32'sd66;
         nb_ff   <= 32'sd197;
         mn_ff   <= 32'sd1966;
      end else if (wr) begin
         unique case (csr_paddr)
            REG_INITIAL_VALUE: init_ff <= csr_pwdata;
            REG_LIFESPAN:      life_ff <= csr_pwdata;
            REG_NOISE_VALUE:   nv_ff   <= {1'b0, csr_pwdata[30:0]};
            REG_NOISE_BIAS:    nb_ff   <= {1'b0, csr_pwdata[30:0]};
            REG_MEAS_NOISE:    mn_ff   <= {1'b0, csr_pwdata[30:0]};
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr)
         REG_INITIAL_VALUE: csr_prdata = init_ff;
         REG_LIFESPAN:      csr_prdata = life_ff;
         REG_NOISE_VALUE:   csr_prdata = nv_ff;
         REG_NOISE_BIAS:    csr_prdata = nb_ff;
         REG_MEAS_NOISE:    csr_prdata = mn_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // operand select for the shared unit
   always_comb begin
      ureq.start = (state_ff == ST_ISSUE);
      ureq.op    = OP_MUL;
      ureq.a     = dt_ff;
      ureq.b     = rate_ff;
      case (step_ff)
         S_RATE_DT: begin ureq.a = dt_ff; ureq.b = rate_ff; end
         S_T:       begin ureq.a = dt_ff; ureq.b = p11_ff; end
         S_P00: begin
            ureq.a = dt_ff;
            ureq.b = add_sat(sub_sat(sub_sat(t_ff, p01_ff), p10_ff), nv_ff);
         end
         S_P11:     begin ureq.a = nb_ff; ureq.b = dt_ff; end
         S_K0: begin
            ureq.op = OP_DIV; ureq.a = p00_ff; ureq.b = add_sat(p00_ff, mn_ff);
         end
         S_K1: begin
            ureq.op = OP_DIV; ureq.a = p10_ff; ureq.b = add_sat(p00_ff, mn_ff);
         end
         S_V:       begin ureq.a = k0_ff; ureq.b = y_ff; end
         S_B:       begin ureq.a = k1_ff; ureq.b = y_ff; end
         S_C0:      begin ureq.a = k0_ff; ureq.b = p00_ff; end
         S_C1:      begin ureq.a = k1_ff; ureq.b = p01_ff; end
         S_C2:      begin ureq.a = k1_ff; ureq.b = p00_ff; end
         default:   begin ureq.a = k0_ff; ureq.b = p01_ff; end
      endcase
   end

   assign r = ursp.result;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      val_in = val_ff; bias_in = bias_ff; rate_in = rate_ff; prior_in = prior_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      t_in = t_ff; k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff;
      mv_in = mv_ff; dt_in = dt_ff; exp_in = exp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               exp_in = 1'b0;
               if (req_restart) begin
                  p00_in = '0; p01_in = '0; p10_in = '0; p11_in = '0;
                  bias_in = '0; rate_in = '0; prior_in = '0; val_in = init_ff;
                  state_in = ST_OUT;
               end else if (req_elapsed_time > life_ff) begin
                  exp_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  dt_in = (req_elapsed_time[31]) ? MaxPos : word_type'(req_elapsed_time);
                  mv_in = req_measured_value;
                  prior_in = val_ff;
                  rate_in = sub_sat(req_measured_rate, bias_ff);
                  step_in = S_RATE_DT;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (ursp.done) begin
               state_in = ST_ISSUE;
               step_in = step_ff + 4'd1;
               case (step_ff)
                  S_RATE_DT: val_in = add_sat(val_ff, r);
                  S_T:       t_in = r;
                  S_P00: begin
                     p00_in = add_sat(p00_ff, r);
                     p01_in = sub_sat(p01_ff, t_ff);
                     p10_in = sub_sat(p10_ff, t_ff);
                  end
                  S_P11:     p11_in = add_sat(p11_ff, r);
                  S_K0:      k0_in = r;
                  S_K1: begin
                     k1_in = r;
                     y_in = sub_sat(mv_ff, val_ff);
                  end
                  S_V:       val_in = add_sat(val_ff, r);
                  S_B:       bias_in = add_sat(bias_ff, r);
                  S_C0:      t_in = r;
                  S_C1:      p11_in = sub_sat(p11_ff, r);
                  S_C2:      p10_in = sub_sat(p10_ff, r);
                  default: begin
                     p01_in = sub_sat(p01_ff, r);
                     p00_in = sub_sat(p00_ff, t_ff);
                     state_in = ST_PREP;
                  end
               endcase
            end
         end
         ST_PREP: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         val_ff <= '0; bias_ff <= '0; rate_ff <= '0; prior_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
         exp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         val_ff <= val_in; bias_ff <= bias_in; rate_ff <= rate_in; prior_ff <= prior_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
         exp_ff <= exp_in;
      end
      t_ff <= t_in; k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      mv_ff <= mv_in; dt_ff <= dt_in;
   end

   // result word
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_estimate = val_ff;
   assign rsp_rate_estimate = rate_ff;
   assign rsp_bias_estimate = bias_ff;
   assign rsp_previous_estimate = prior_ff;
   assign rsp_expired = exp_ff;
endmodule

/* rtl/core/abkf_checker.sv */
module abkf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_expired,
   input logic [31:0] rsp_estimate,
   input logic csr_pready
);
   // no word taken while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken during result");
   // result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_estimate)
      && $stable(rsp_expired))
      else $error("result dropped");
   // accepted word leads to busy
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("no busy after accept");
   // register port never waits
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      csr_pready) else $error("pready low");
endmodule

bind angle_bias_kalman_filter_core abkf_checker u_abkf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_expired(rsp_expired),
   .rsp_estimate(rsp_estimate), .csr_pready(csr_pready)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import abkf_pkg::*;

   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic        restart;
      logic [31:0] value;
      logic [31:0] rate;
      logic [31:0] elapsed;
   } step_word_type;

   typedef struct packed {
      logic [31:0] estimate;
      logic [31:0] rate_estimate;
      logic [31:0] bias_estimate;
      logic [31:0] previous_estimate;
      logic        expired;
   } filter_out_type;

   logic clock;
   logic reset;
   logic req_valid, req_stall, req_restart;
   logic signed [31:0] req_measured_value, req_measured_rate;
   logic [31:0] req_elapsed_time;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_estimate, rsp_rate_estimate, rsp_bias_estimate;
   logic signed [31:0] rsp_previous_estimate;
   logic rsp_expired;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AddrBits-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   angle_bias_kalman_filter_core i_dut (.*);

   // filter state mirror
   logic signed [63:0] cfg_initial, cfg_noise_value, cfg_noise_bias, cfg_meas_noise;
   logic [31:0] cfg_lifespan;
   logic signed [63:0] est_value, est_bias, est_rate, est_prior;
   logic signed [63:0] cov [4];

   step_word_type pending_steps [$];
   filter_out_type expected_outputs [$];
   int errors = 0;
   int steps_sent = 0, results_seen = 0, expired_seen = 0, restarts_sent = 0;
   int idle_cycles = 0;
   bit long_hold = 0;
   int hold_count = 0;
   bit req_taken = 0;
   int stall_left = 0;

   localparam logic signed [63:0] WMax = 64'sd2147483647;
   localparam logic signed [63:0] WMin = -64'sd2147483648;

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      return v > WMax ? WMax : (v < WMin ? WMin : v);
   endfunction

   function automatic logic signed [63:0] q_add(logic signed [63:0] a, b);
      return clamp32(a + b);
   endfunction

   function automatic logic signed [63:0] q_sub(logic signed [63:0] a, b);
      return clamp32(a - b);
   endfunction

   // product shifted by the fraction, magnitude truncated
   function automatic logic signed [63:0] q_mul(logic signed [63:0] a, b);
      logic [127:0] p;
      logic [63:0] ma, mb;
      logic neg;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      p = (ma * mb) >> FracBits;
      if (neg) return p > 128'd2147483648 ? WMin : -$signed({1'b0, p[62:0]});
      return p > 128'd2147483647 ? WMax : $signed({1'b0, p[62:0]});
   endfunction

   // gain quotient, zero when the divisor is zero
   function automatic logic signed [63:0] q_div(logic signed [63:0] a, s);
      logic [127:0] q;
      logic [63:0] ma, ms;
      logic neg;
      ma = a < 0 ? -a : a;
      ms = s < 0 ? -s : s;
      if (ms == 0) return 0;
      neg = (a < 0) != (s < 0);
      q = ({64'd0, ma} << FracBits) / ms;
      if (neg) return q > 128'd2147483648 ? WMin : -$signed({1'b0, q[62:0]});
      return q > 128'd2147483647 ? WMax : $signed({1'b0, q[62:0]});
   endfunction

   function automatic filter_out_type run_filter_step(step_word_type w);
      filter_out_type o;
      logic signed [63:0] dt, mv, mr, t, s, k0, k1, y, p00, p01;
      o.expired = 0;
      if (w.restart) begin
         foreach (cov[i]) cov[i] = 0;
         est_bias = 0;
         est_rate = 0;
         est_prior = 0;
         est_value = cfg_initial;
      end else if (w.elapsed > cfg_lifespan) begin
         o.expired = 1;
      end else begin
         dt = clamp32($signed({32'd0, w.elapsed}));
         mv = $signed(w.value);
         mr = $signed(w.rate);
         est_prior = est_value;
         est_rate = q_sub(mr, est_bias);
         est_value = q_add(est_value, q_mul(dt, est_rate));
         t = q_mul(dt, cov[3]);
         cov[0] = q_add(cov[0], q_mul(dt,
            q_add(q_sub(q_sub(t, cov[1]), cov[2]), cfg_noise_value)));
         cov[1] = q_sub(cov[1], t);
         cov[2] = q_sub(cov[2], t);
         cov[3] = q_add(cov[3], q_mul(cfg_noise_bias, dt));
         s = q_add(cov[0], cfg_meas_noise);
         k0 = q_div(cov[0], s);
         k1 = q_div(cov[2], s);
         y = q_sub(mv, est_value);
         est_value = q_add(est_value, q_mul(k0, y));
         est_bias = q_add(est_bias, q_mul(k1, y));
         p00 = cov[0];
         p01 = cov[1];
         cov[0] = q_sub(cov[0], q_mul(k0, p00));
         cov[1] = q_sub(cov[1], q_mul(k0, p01));
         cov[2] = q_sub(cov[2], q_mul(k1, p00));
         cov[3] = q_sub(cov[3], q_mul(k1, p01));
      end
      o.estimate = est_value[31:0];
      o.rate_estimate = est_rate[31:0];
      o.bias_estimate = est_bias[31:0];
      o.previous_estimate = est_prior[31:0];
      return o;
   endfunction

   // clock
   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // input driver
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_taken) begin
         // hold payload until taken
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 0;
      end else if (pending_steps.size() > 0) begin
         req_valid <= 1;
         req_taken = 0;
         {req_restart, req_measured_value, req_measured_rate, req_elapsed_time}
            <= pending_steps.pop_front();
         gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                   : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end else begin
         req_valid <= 0;
      end
   end

   // accepted words feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_outputs.push_back(run_filter_step(
            {req_restart, req_measured_value, req_measured_rate, req_elapsed_time}));
         req_taken = 1;
         steps_sent++;
         if (req_restart) restarts_sent++;
      end
   end

   // result stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (long_hold) begin
         rsp_stall <= 1;
         if (hold_count < 600) hold_count <= hold_count + 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 19) == 0) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(10, 60);
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      end
   end

   // result monitor
   always @(posedge clock) begin
      filter_out_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_estimate, rsp_rate_estimate, rsp_bias_estimate,
                rsp_previous_estimate, rsp_expired};
         results_seen++;
         if (rsp_expired) expired_seen++;
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = expected_outputs.pop_front();
            if (got.estimate !== want.estimate)
               $display("%0t: estimate exp %h got %h", $time, want.estimate,
                        got.estimate);
            if (got.rate_estimate !== want.rate_estimate)
               $display("%0t: rate_estimate exp %h got %h", $time,
                        want.rate_estimate, got.rate_estimate);
            if (got.bias_estimate !== want.bias_estimate)
               $display("%0t: bias_estimate exp %h got %h", $time,
                        want.bias_estimate, got.bias_estimate);
            if (got.previous_estimate !== want.previous_estimate)
               $display("%0t: previous_estimate exp %h got %h", $time,
                        want.previous_estimate, got.previous_estimate);
            if (got.expired !== want.expired)
               $display("%0t: expired exp %b got %b", $time, want.expired,
                        got.expired);
            if (got !== want) errors++;
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_psel || pending_steps.size() == 0 && expected_outputs.size() == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_outputs.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(reg_addr_type addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (addr)
         REG_INITIAL_VALUE: cfg_initial = $signed(data);
         REG_LIFESPAN:      cfg_lifespan = data;
         REG_NOISE_VALUE:   cfg_noise_value = {33'd0, data[30:0]};
         REG_NOISE_BIAS:    cfg_noise_bias = {33'd0, data[30:0]};
         REG_MEAS_NOISE:    cfg_meas_noise = {33'd0, data[30:0]};
         default: ;
      endcase
   endtask

   task automatic drain_and_settle();
      while (pending_steps.size() > 0 || expected_outputs.size() > 0 || req_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 4) : -$urandom_range(0, 4);
         default: return $urandom;
      endcase
   endfunction

   // realistic sample: small angles and rates, dt within lifespan mostly
   function automatic step_word_type rand_step(logic [31:0] life);
      step_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.restart = (pick < 4);
      if (pick < 70) begin
         w.value = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
         w.rate = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
         w.elapsed = (life == 0) ? 0 : $urandom_range(0, life > 32'h4000 ? 32'h4000 : life);
      end else begin
         w.value = rand_word();
         w.rate = rand_word();
         w.elapsed = (pick < 85) ? $urandom : rand_word();
      end
      return w;
   endfunction

   task automatic random_phase(int count);
      repeat (count) pending_steps.push_back(rand_step(cfg_lifespan));
   endtask

   // stimulus
   initial begin
      reset = 1;
      req_valid = 0;
      req_restart = 0;
      req_measured_value = 0;
      req_measured_rate = 0;
      req_elapsed_time = 0;
      rsp_stall = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = REG_INITIAL_VALUE;
      csr_pwdata = 0;
      cfg_initial = 0;
      cfg_lifespan = 65536;
      cfg_noise_value = 66;
      cfg_noise_bias = 197;
      cfg_meas_noise = 1966;
      est_value = 0; est_bias = 0; est_rate = 0; est_prior = 0;
      foreach (cov[i]) cov[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, extremes, expiry, restart
      pending_steps.push_back({1'b0, 32'sh00010000, 32'sh00008000, 32'h00000800});
      pending_steps.push_back({1'b0, 32'h7fffffff, 32'h7fffffff, 32'h00010000});
      pending_steps.push_back({1'b0, 32'h80000000, 32'h80000000, 32'h00010000});
      pending_steps.push_back({1'b0, 32'h00000000, 32'h00000000, 32'h00000000});
      pending_steps.push_back({1'b0, 32'h12345678, 32'h00000001, 32'h00010001});
      pending_steps.push_back({1'b0, 32'h00000001, 32'hffffffff, 32'hffffffff});
      pending_steps.push_back({1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      pending_steps.push_back({1'b0, 32'hfff00000, 32'h00050000, 32'h00001000});
      drain_and_settle();

      // zero divisor and extreme registers
      write_reg(REG_MEAS_NOISE, 32'h0);
      write_reg(REG_NOISE_VALUE, 32'h0);
      write_reg(REG_INITIAL_VALUE, 32'h80000000);
      write_reg(REG_LIFESPAN, 32'hffffffff);
      pending_steps.push_back({1'b1, 32'h0, 32'h0, 32'h0});
      pending_steps.push_back({1'b0, 32'h00010000, 32'h0, 32'h0});
      pending_steps.push_back({1'b0, 32'h7fffffff, 32'h80000000, 32'hffffffff});
      pending_steps.push_back({1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000});
      drain_and_settle();

      write_reg(REG_NOISE_VALUE, 32'hffffffff);
      write_reg(REG_NOISE_BIAS, 32'h7fffffff);
      write_reg(REG_MEAS_NOISE, 32'h7fffffff);
      write_reg(REG_INITIAL_VALUE, 32'h7fffffff);
      write_reg(REG_LIFESPAN, 32'h0);
      pending_steps.push_back({1'b1, 32'h0, 32'h0, 32'h0});
      pending_steps.push_back({1'b0, 32'h00010000, 32'h00010000, 32'h0});
      pending_steps.push_back({1'b0, 32'h00010000, 32'h00010000, 32'h1});
      random_phase(60);
      drain_and_settle();

      // default-like tuning, with a long receiver hold
      write_reg(REG_INITIAL_VALUE, 32'h00020000);
      write_reg(REG_LIFESPAN, 32'h00010000);
      write_reg(REG_NOISE_VALUE, 32'd66);
      write_reg(REG_NOISE_BIAS, 32'd197);
      write_reg(REG_MEAS_NOISE, 32'd1966);
      pending_steps.push_back({1'b1, 32'h0, 32'h0, 32'h0});
      long_hold = 1;
      random_phase(250);
      while (hold_count < 600) @(posedge clock);
      long_hold = 0;
      drain_and_settle();

      // random tuning
      write_reg(REG_INITIAL_VALUE, $urandom);
      write_reg(REG_LIFESPAN, $urandom_range(1, 32'h00100000));
      write_reg(REG_NOISE_VALUE, $urandom_range(0, 32'h00010000));
      write_reg(REG_NOISE_BIAS, $urandom_range(0, 32'h00010000));
      write_reg(REG_MEAS_NOISE, $urandom_range(1, 32'h00100000));
      random_phase(330);
      drain_and_settle();

      $display("covered %0d steps (%0d restarts, %0d expired), %0d results checked",
               steps_sent, restarts_sent, expired_seen, results_seen);
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/abkf_pkg.sv
rtl/core/abkf_unit.sv
rtl/core/angle_bias_kalman_filter_core.sv
rtl/core/abkf_checker.sv
sim/tb.sv
